// ===== hw/rtl/tcce_pkg.sv =====
// Package for the text console cursor engine.
// Holds widths, control codes, queue entry and geometry types shared by all files.
// No dependencies.
package tcce_pkg;

    localparam int CH_W       = 8;
    localparam int COLOR_W    = 32;
    localparam int POS_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Tab stops must stay a power of two, as the stop is found by masking.
    localparam int TAB_STOP = 8;

    localparam logic [CH_W-1:0] CH_BS  = 8'h08;
    localparam logic [CH_W-1:0] CH_TAB = 8'h09;
    localparam logic [CH_W-1:0] CH_LF  = 8'h0a;
    localparam logic [CH_W-1:0] CH_VT  = 8'h0b;
    localparam logic [CH_W-1:0] CH_FF  = 8'h0c;
    localparam logic [CH_W-1:0] CH_CR  = 8'h0d;

    localparam logic [CH_W-1:0]    GLYPH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0]    GLYPH_NL     = 8'h0a;
    localparam logic [CH_W-1:0]    GLYPH_CURSOR = 8'h00;
    localparam logic [COLOR_W-1:0] CURSOR_FG    = 32'h0088_8888;
    localparam logic [POS_W-1:0]   POS_MAX      = 8'hff;

    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_SCROLL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BGR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd3;

    localparam logic [POS_W-1:0] COLS_RESET = 8'd80;
    localparam logic [POS_W-1:0] ROWS_RESET = 8'd25;

    typedef enum logic [2:0] {
        OP_PRINT,
        OP_BS,
        OP_TAB,
        OP_LF,
        OP_VT,
        OP_FF,
        OP_CR
    } op_t;

    typedef enum logic [2:0] {
        ST_HEAD,
        ST_SCROLL_A,
        ST_CHAR,
        ST_END,
        ST_CURSOR
    } step_t;

    typedef struct packed {
        op_t                op;
        logic [CH_W-1:0]    ch;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        logic [COLOR_W-1:0] dim_fg;
        logic [COLOR_W-1:0] dim_bg;
        logic               last;
    } tcce_entry_t;

    typedef struct packed {
        logic [POS_W-1:0] cols;
        logic [POS_W-1:0] rows;
    } tcce_geom_t;

endpackage

// ===== hw/rtl/tcce_in_if.sv =====
// Character channel of the text console cursor engine.
// Depends on tcce_pkg.
interface tcce_in_if import tcce_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    ch;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
    logic               last_in_string;

    modport source (output valid, ch, fg_color, bg_color, last_in_string, input ready);
    modport sink (input valid, ch, fg_color, bg_color, last_in_string, output ready);

endinterface

// ===== hw/rtl/tcce_out_if.sv =====
// Command channel of the text console cursor engine.
// Depends on tcce_pkg.
interface tcce_out_if import tcce_pkg::*; ();

    logic               valid;
    logic               ready;
    logic               cmd_kind;
    logic [CH_W-1:0]    glyph;
    logic [POS_W-1:0]   cell_col;
    logic [POS_W-1:0]   cell_row;
    logic [COLOR_W-1:0] draw_fg;
    logic [COLOR_W-1:0] draw_bg;
    logic               last_result;

    modport source (output valid, cmd_kind, glyph, cell_col, cell_row, draw_fg, draw_bg,
                    last_result, input ready);
    modport sink (input valid, cmd_kind, glyph, cell_col, cell_row, draw_fg, draw_bg,
                  last_result, output ready);

endinterface

// ===== hw/rtl/tcce_front.sv =====
// Front end: accepts character beats, classifies the code and prepares colours.
// Depends on tcce_pkg and tcce_in_if; feeds tcce_queue.
module tcce_front import tcce_pkg::*;
(
    tcce_in_if.sink      chars,
    input  logic         enabled,
    input  logic         bgr,
    input  logic         full,
    output logic         push,
    output tcce_entry_t  entry
);

    logic [COLOR_W-1:0] fg_ord;
    op_t                op_code;

    assign chars.ready = !full;
    assign push        = chars.valid && !full && enabled;

    assign fg_ord = bgr ? {8'h00, chars.fg_color[7:0], chars.fg_color[15:8],
                           chars.fg_color[23:16]}
                        : chars.fg_color;

    always_comb
    begin
        case (chars.ch)
            CH_BS:   op_code = OP_BS;
            CH_TAB:  op_code = OP_TAB;
            CH_LF:   op_code = OP_LF;
            CH_VT:   op_code = OP_VT;
            CH_FF:   op_code = OP_FF;
            CH_CR:   op_code = OP_CR;
            default: op_code = OP_PRINT;
        endcase
    end

    assign entry.op     = op_code;
    assign entry.ch     = chars.ch;
    assign entry.fg     = fg_ord;
    assign entry.bg     = chars.bg_color;
    // Three quarters of the colour, taken from the quarter so that low bits drop.
    assign entry.dim_fg = {2'b00, fg_ord[31:2]} + {1'b0, fg_ord[31:2], 1'b0};
    assign entry.dim_bg = {2'b00, chars.bg_color[31:2]} + {1'b0, chars.bg_color[31:2], 1'b0};
    assign entry.last   = chars.last_in_string;

endmodule

// ===== hw/rtl/tcce_queue.sv =====
// Short first-word-fall-through queue between the front end and the sequencer.
// Depends on tcce_pkg.
module tcce_queue import tcce_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  tcce_entry_t push_data,
    input  logic        pop,
    output logic        full,
    output logic        empty,
    output tcce_entry_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tcce_entry_t      slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/tcce_back.sv =====
// Back end: steps through the commands of each queued character, one per cycle while the
// receiver does not stall, keeps the cursor and drives the registered command channel. Depends on tcce_pkg.
module tcce_back import tcce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tcce_geom_t  geom,
    input  logic        empty,
    input  tcce_entry_t head,
    output logic        pop,
    tcce_out_if.source  cmds
);

    step_t              step_reg, step_next;
    logic [POS_W-1:0]   col_reg, col_next;
    logic [POS_W-1:0]   row_reg, row_next;
    logic               out_valid_reg;
    logic               kind_reg, kind_next;
    logic [CH_W-1:0]    glyph_reg, glyph_next;
    logic [POS_W-1:0]   cell_col_reg, cell_col_next;
    logic [POS_W-1:0]   cell_row_reg, cell_row_next;
    logic [COLOR_W-1:0] fg_reg, fg_next;
    logic [COLOR_W-1:0] bg_reg, bg_next;
    logic               last_reg;

    logic               advance, fire, item_done;
    logic [POS_W-1:0]   rows_eff;
    logic [POS_W:0]     row_inc;
    logic               adv_scroll;
    logic [POS_W-1:0]   adv_row;
    logic [POS_W-1:0]   col_inc;
    logic [POS_W:0]     tab_sum;
    logic [POS_W:0]     tab_stop;
    logic [POS_W-1:0]   tab_col;
    logic               wrap_hit;
    logic               row_full;
    step_t              tail;

    assign advance = !out_valid_reg || cmds.ready;
    assign fire    = advance && !empty;
    assign pop     = fire && item_done;

    assign rows_eff   = (geom.rows == '0) ? POS_W'(1) : geom.rows;
    assign row_inc    = {1'b0, row_reg} + 1'b1;
    assign adv_scroll = row_inc >= {1'b0, rows_eff};
    assign adv_row    = adv_scroll ? rows_eff - 1'b1 : row_inc[POS_W-1:0];
    assign col_inc    = (col_reg == POS_MAX) ? col_reg : col_reg + 1'b1;
    assign tab_sum    = {1'b0, col_reg} + (POS_W+1)'(TAB_STOP);
    assign tab_stop   = tab_sum & ~((POS_W+1)'(TAB_STOP - 1));
    assign tab_col    = tab_stop[POS_W] ? POS_MAX : tab_stop[POS_W-1:0];
    assign wrap_hit   = !head.last && (({1'b0, col_reg} + 1'b1) == {1'b0, geom.cols});
    assign row_full   = col_reg == geom.cols;
    assign tail       = head.last ? ST_END : ST_HEAD;

    always_comb
    begin
        step_next = ST_HEAD;
        case (step_reg)
            ST_HEAD:
            begin
                case (head.op)
                    OP_LF, OP_VT: step_next = adv_scroll ? ST_SCROLL_A : tail;
                    OP_PRINT:
                    begin
                        if (wrap_hit)
                        begin
                            step_next = adv_scroll ? ST_SCROLL_A : ST_CHAR;
                        end
                        else
                        begin
                            step_next = tail;
                        end
                    end
                    default: step_next = tail;
                endcase
            end
            ST_SCROLL_A: step_next = (head.op == OP_PRINT) ? ST_CHAR : tail;
            ST_CHAR:     step_next = tail;
            ST_END:      step_next = (row_full && adv_scroll) ? ST_CURSOR : ST_HEAD;
            ST_CURSOR:   step_next = ST_HEAD;
            default:     step_next = ST_HEAD;
        endcase
    end

    assign item_done = step_next == ST_HEAD;

    always_comb
    begin
        kind_next     = CMD_DRAW;
        glyph_next    = GLYPH_CURSOR;
        fg_next       = '0;
        bg_next       = '0;
        cell_col_next = col_reg;
        cell_row_next = row_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        case (step_reg)
            ST_HEAD:
            begin
                glyph_next = GLYPH_SPACE;
                case (head.op)
                    OP_FF:
                    begin
                        kind_next     = CMD_SCROLL;
                        glyph_next    = '0;
                        cell_col_next = '0;
                        cell_row_next = '0;
                    end
                    OP_LF:
                    begin
                        col_next = '0;
                        row_next = adv_row;
                    end
                    OP_VT:  row_next = adv_row;
                    OP_TAB: col_next = tab_col;
                    OP_CR:  col_next = '0;
                    OP_BS:  col_next = (col_reg == '0) ? col_reg : col_reg - 1'b1;
                    OP_PRINT:
                    begin
                        if (wrap_hit)
                        begin
                            glyph_next = GLYPH_NL;
                            fg_next    = head.dim_fg;
                            bg_next    = head.dim_bg;
                            col_next   = '0;
                            row_next   = adv_row;
                        end
                        else
                        begin
                            glyph_next = head.ch;
                            fg_next    = head.fg;
                            bg_next    = head.bg;
                            col_next   = col_inc;
                        end
                    end
                    default: glyph_next = GLYPH_SPACE;
                endcase
            end
            ST_SCROLL_A:
            begin
                kind_next     = CMD_SCROLL;
                cell_col_next = '0;
                cell_row_next = '0;
            end
            ST_CHAR:
            begin
                glyph_next = head.ch;
                fg_next    = head.fg;
                bg_next    = head.bg;
                col_next   = col_inc;
            end
            ST_END:
            begin
                fg_next = CURSOR_FG;
                if (row_full)
                begin
                    col_next = '0;
                    row_next = adv_row;
                    if (adv_scroll)
                    begin
                        kind_next     = CMD_SCROLL;
                        fg_next       = '0;
                        cell_col_next = '0;
                        cell_row_next = '0;
                    end
                    else
                    begin
                        cell_col_next = '0;
                        cell_row_next = adv_row;
                    end
                end
            end
            ST_CURSOR: fg_next = CURSOR_FG;
            default:   fg_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_HEAD;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= !empty;
            end
            if (fire)
            begin
                step_reg <= step_next;
                col_reg  <= col_next;
                row_reg  <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            kind_reg     <= kind_next;
            glyph_reg    <= glyph_next;
            cell_col_reg <= cell_col_next;
            cell_row_reg <= cell_row_next;
            fg_reg       <= fg_next;
            bg_reg       <= bg_next;
            last_reg     <= item_done;
        end
    end

    assign cmds.valid       = out_valid_reg;
    assign cmds.cmd_kind    = kind_reg;
    assign cmds.glyph       = glyph_reg;
    assign cmds.cell_col    = cell_col_reg;
    assign cmds.cell_row    = cell_row_reg;
    assign cmds.draw_fg     = fg_reg;
    assign cmds.draw_bg     = bg_reg;
    assign cmds.last_result = last_reg;

`ifndef SYNTH
    a_busy_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != ST_HEAD |-> !empty)
        else $error("Sequencer is inside an item while the queue is empty.");

    a_char_is_print: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == ST_CHAR |-> head.op == OP_PRINT)
        else $error("Deferred glyph step reached for a control code.");

    a_cursor_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == ST_END || step_reg == ST_CURSOR) |-> head.last)
        else $error("String end handling for a character that does not end its string.");

    a_scroll_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == CMD_SCROLL) |->
        (glyph_reg == '0 && cell_col_reg == '0 && cell_row_reg == '0 &&
         fg_reg == '0 && bg_reg == '0))
        else $error("Scroll command carries a non-zero cell payload.");
`endif

endmodule

// ===== hw/rtl/text_console_cursor_engine.sv =====
// Text console cursor engine: turns a stream of characters into draw and scroll commands.
// Channel chars carries one character per beat with its colours and a last-of-string flag;
// channel cmds carries one draw or scroll command per beat, last_result marking the final
// command of a character. Both use valid/ready, a beat moving when both are high.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must write them
// only while the block is idle, as the block does not enforce it. Index 0 enables the console,
// 1 selects BGR order, 2 sets the columns, 3 the rows. With the console disabled, characters
// are taken and dropped. A character enters a queue of QUEUE_DEPTH entries in the cycle it is
// accepted, and its commands are offered from the output register. Each character gives one to
// four commands, and the sequencer issues one command per cycle while the receiver does not
// stall; a plain glyph in mid-string gives a single command.
// The front end keeps taking characters while the queue has room, also while the receiver
// stalls; a stalled command holds in the output register and the sequencer waits.
// Reset puts the cursor at column 0, row 0, empties the queue, disables the console and
// restores an 80 by 25 screen in RGB order.
// Depends on tcce_pkg, tcce_in_if, tcce_out_if, tcce_front, tcce_queue and tcce_back.
module text_console_cursor_engine import tcce_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    tcce_in_if.sink               chars,
    tcce_out_if.source            cmds,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic             enabled_reg;
    logic             bgr_reg;
    logic [POS_W-1:0] cols_reg;
    logic [POS_W-1:0] rows_reg;
    tcce_geom_t       geom;
    tcce_entry_t      push_entry, head_entry;
    logic             push, pop, full, empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            bgr_reg     <= 1'b0;
            cols_reg    <= COLS_RESET;
            rows_reg    <= ROWS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLE: enabled_reg <= cfg_data[0];
                CFG_BGR:    bgr_reg     <= cfg_data[0];
                CFG_COLS:   cols_reg    <= cfg_data[POS_W-1:0];
                CFG_ROWS:   rows_reg    <= cfg_data[POS_W-1:0];
                default:    enabled_reg <= enabled_reg;
            endcase
        end
    end

    assign geom.cols = cols_reg;
    assign geom.rows = rows_reg;

    tcce_front u_front (
        .chars   (chars),
        .enabled (enabled_reg),
        .bgr     (bgr_reg),
        .full    (full),
        .push    (push),
        .entry   (push_entry)
    );

    tcce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .pop       (pop),
        .full      (full),
        .empty     (empty),
        .head      (head_entry)
    );

    tcce_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .geom  (geom),
        .empty (empty),
        .head  (head_entry),
        .pop   (pop),
        .cmds  (cmds)
    );

endmodule
